// ----- sv/h264qd_pkg.sv -----
// ----------------------------------------------------------------------------
// h264qd_pkg
// shared types, constants and helpers for the 4x4 quantize / dequantize unit
// ----------------------------------------------------------------------------
package h264qd_pkg;

  localparam int QP_CLASSES       = 6;
  localparam int BLOCK_COEFS_DEF  = 16;

  localparam int MODE_W     = 2;
  localparam int COEF_W     = 16;
  localparam int POS_W      = 4;
  localparam int ROW_W      = 3;
  localparam int TVAL_W     = 16;
  localparam int VALUE_W    = 32;

  localparam int QP_W       = 6;
  localparam int BIAS_W     = 22;
  localparam int QSHIFT_W   = 5;
  localparam int DQSHIFT_W  = 4;
  localparam int CFG_DATA_W = 22;

  localparam logic [QP_W-1:0]     QP_RST     = 6'd26;
  localparam logic [BIAS_W-1:0]   BIAS_RST   = '0;
  localparam logic [QSHIFT_W-1:0] QSHIFT_RST = 5'd15;

  // reciprocal of six for 6-bit values, scaled by 256
  localparam int RECIP6 = 43;

  typedef enum logic [MODE_W-1:0] {
    MODE_QUANT    = 2'd0,
    MODE_DEQUANT  = 2'd1,
    MODE_LOAD_Q   = 2'd2,
    MODE_LOAD_DQ  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_QUANT_QP   = 2'd0,
    CFG_BIAS       = 2'd1,
    CFG_QSHIFT     = 2'd2,
    CFG_DEQUANT_QP = 2'd3
  } cfg_reg_t;

  function automatic logic [DQSHIFT_W-1:0] qp_div6(input logic [QP_W-1:0] qp);
    logic [11:0] p;
    p = 12'(qp) * 12'(RECIP6);
    return p[11:8];
  endfunction

  function automatic logic [ROW_W-1:0] qp_mod6(input logic [QP_W-1:0] qp);
    logic [QP_W-1:0] r;
    r = qp - QP_W'(qp_div6(qp)) * QP_W'(QP_CLASSES);
    return r[ROW_W-1:0];
  endfunction

endpackage

// ----- sv/h264qd_coef_if.sv -----
// ----------------------------------------------------------------------------
// h264qd_coef_if
// input channel: coefficients and table loads
// ----------------------------------------------------------------------------
interface h264qd_coef_if;
  logic                               valid;
  logic                               ready;
  h264qd_pkg::mode_t                  mode;
  logic signed [h264qd_pkg::COEF_W-1:0] coef;
  logic [h264qd_pkg::POS_W-1:0]       position;
  logic [h264qd_pkg::ROW_W-1:0]       row_class;
  logic [h264qd_pkg::TVAL_W-1:0]      table_value;
  logic                               last;

  modport source (output valid, mode, coef, position, row_class, table_value, last,
                  input ready);
  modport sink   (input valid, mode, coef, position, row_class, table_value, last,
                  output ready);
endinterface

// ----- sv/h264qd_res_if.sv -----
// ----------------------------------------------------------------------------
// h264qd_res_if
// output channel: levels or dequantized coefficients
// ----------------------------------------------------------------------------
interface h264qd_res_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [h264qd_pkg::VALUE_W-1:0] value;
  logic                                  block_nonzero;
  logic                                  last_res;

  modport source (output valid, value, block_nonzero, last_res, input ready);
  modport sink   (input valid, value, block_nonzero, last_res, output ready);
endinterface

// ----- sv/h264_quant_dequant_4x4.sv -----
// stages: table read, multiply, bias add or dequantize shift, then quantize shift into the
// output register, whose contents results.valid marks
// throughput: one transaction per cycle, one table read, multiply or shift per stage;
// input stalls only once all four stages hold a result the output has not taken
// reset: configuration returns to qp 26, bias 0, shift 15; the nonzero flag clears;
// table contents are undefined until loaded
// ----------------------------------------------------------------------------
// h264_quant_dequant_4x4
// 4x4 integer quantize / dequantize with loadable multiplier tables
// ----------------------------------------------------------------------------
module h264_quant_dequant_4x4 (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  h264qd_pkg::cfg_reg_t                  cfg_index,
  input  logic [h264qd_pkg::CFG_DATA_W-1:0]     cfg_data,
  h264qd_coef_if.sink                           coefs,
  h264qd_res_if.source                          results
);

  localparam int BLOCK_COEFS = h264qd_pkg::BLOCK_COEFS_DEF;
  localparam int DEPTH = h264qd_pkg::QP_CLASSES * BLOCK_COEFS;
  localparam int AW    = $clog2(DEPTH);

  // configuration
  logic [h264qd_pkg::QP_W-1:0]     quant_qp;
  logic [h264qd_pkg::BIAS_W-1:0]   rounding_bias;
  logic [h264qd_pkg::QSHIFT_W-1:0] quant_shift;
  logic [h264qd_pkg::QP_W-1:0]     dequant_qp;

  always_ff @(posedge clk) begin
    if (rst) begin
      quant_qp      <= h264qd_pkg::QP_RST;
      rounding_bias <= h264qd_pkg::BIAS_RST;
      quant_shift   <= h264qd_pkg::QSHIFT_RST;
      dequant_qp    <= h264qd_pkg::QP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        h264qd_pkg::CFG_QUANT_QP:   quant_qp      <= cfg_data[h264qd_pkg::QP_W-1:0];
        h264qd_pkg::CFG_BIAS:       rounding_bias <= cfg_data[h264qd_pkg::BIAS_W-1:0];
        h264qd_pkg::CFG_QSHIFT:     quant_shift   <= cfg_data[h264qd_pkg::QSHIFT_W-1:0];
        h264qd_pkg::CFG_DEQUANT_QP: dequant_qp    <= cfg_data[h264qd_pkg::QP_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;
  logic in_acc, in_proc, load_q, load_dq, row_ok;

  assign adv4 = !v4 || results.ready;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;

  assign coefs.ready = adv1;
  assign in_acc  = coefs.valid && adv1;
  assign in_proc = (coefs.mode == h264qd_pkg::MODE_QUANT) ||
                   (coefs.mode == h264qd_pkg::MODE_DEQUANT);
  assign row_ok  = coefs.row_class < h264qd_pkg::ROW_W'(h264qd_pkg::QP_CLASSES);
  assign load_q  = in_acc && row_ok && (coefs.mode == h264qd_pkg::MODE_LOAD_Q);
  assign load_dq = in_acc && row_ok && (coefs.mode == h264qd_pkg::MODE_LOAD_DQ);

  // table addressing
  logic [AW-1:0] wr_addr, q_addr, dq_addr;

  assign wr_addr = AW'(coefs.row_class) * AW'(BLOCK_COEFS) + AW'(coefs.position);
  assign q_addr  = AW'(h264qd_pkg::qp_mod6(quant_qp)) * AW'(BLOCK_COEFS)
                   + AW'(coefs.position);
  assign dq_addr = AW'(h264qd_pkg::qp_mod6(dequant_qp)) * AW'(BLOCK_COEFS)
                   + AW'(coefs.position);

  // multiplier tables
  logic [h264qd_pkg::TVAL_W-1:0] quant_table   [DEPTH];
  logic [h264qd_pkg::TVAL_W-1:0] dequant_table [DEPTH];
  logic [h264qd_pkg::TVAL_W-1:0] q_rd, dq_rd;

  always_ff @(posedge clk) begin
    if (load_q) begin
      quant_table[wr_addr] <= coefs.table_value;
    end
    if (adv1) begin
      q_rd <= quant_table[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (load_dq) begin
      dequant_table[wr_addr] <= coefs.table_value;
    end
    if (adv1) begin
      dq_rd <= dequant_table[dq_addr];
    end
  end

  // stage payloads
  logic                                  s1_quant, s1_last;
  logic signed [h264qd_pkg::COEF_W-1:0]  s1_coef;
  logic [h264qd_pkg::DQSHIFT_W-1:0]      s1_shl;
  logic [h264qd_pkg::TVAL_W-1:0]         s1_m;
  logic signed [h264qd_pkg::COEF_W+h264qd_pkg::TVAL_W:0] s1_mul;

  logic                                  s2_quant, s2_last, s2_pos;
  logic [h264qd_pkg::DQSHIFT_W-1:0]      s2_shl;
  logic [h264qd_pkg::VALUE_W-1:0]        s2_prod;

  logic                                  s3_quant, s3_last, s3_pos;
  logic [h264qd_pkg::VALUE_W-1:0]        s3_sum;
  logic [h264qd_pkg::VALUE_W-1:0]        s3_shifted, s3_level, s3_result;
  logic                                  s3_nz, seen_or;

  logic                                  nonzero_seen;

  assign s1_m   = s1_quant ? q_rd : dq_rd;
  assign s1_mul = s1_coef * $signed({1'b0, s1_m});

  assign s3_shifted = $unsigned($signed(s3_sum) >>> quant_shift);
  assign s3_level   = s3_pos ? s3_shifted : (32'd0 - s3_shifted);
  assign s3_result  = s3_quant ? s3_level : s3_sum;
  assign s3_nz      = s3_shifted != 32'd0;
  assign seen_or    = nonzero_seen || s3_nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      nonzero_seen <= 1'b0;
    end else begin
      if (adv1) v1 <= in_acc && in_proc;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv4 && v3 && s3_quant) begin
        nonzero_seen <= s3_last ? 1'b0 : seen_or;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_quant <= coefs.mode == h264qd_pkg::MODE_QUANT;
      s1_last  <= coefs.last;
      s1_coef  <= coefs.coef;
      s1_shl   <= h264qd_pkg::qp_div6(dequant_qp);
    end
    if (adv2) begin
      s2_quant <= s1_quant;
      s2_last  <= s1_last;
      s2_pos   <= s1_coef > 0;
      s2_shl   <= s1_shl;
      s2_prod  <= $unsigned(s1_mul[h264qd_pkg::VALUE_W-1:0]);
    end
    if (adv3) begin
      s3_quant <= s2_quant;
      s3_last  <= s2_last;
      s3_pos   <= s2_pos;
      if (!s2_quant) begin
        s3_sum <= s2_prod << s2_shl;
      end else if (s2_pos) begin
        s3_sum <= 32'(rounding_bias) + s2_prod;
      end else begin
        s3_sum <= 32'(rounding_bias) - s2_prod;
      end
    end
    if (adv4) begin
      results.value         <= $signed(s3_result);
      results.block_nonzero <= s3_quant && s3_last && seen_or;
      results.last_res      <= s3_last;
    end
  end

  assign results.valid = v4;

`ifndef NO_ASSERTIONS
  a_flag_on_last: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.block_nonzero |-> results.last_res)
    else $error("block_nonzero set outside a last result");

  a_flag_cleared: assert property (@(posedge clk) disable iff (rst)
    adv4 && v3 && s3_quant && s3_last |=> !nonzero_seen)
    else $error("nonzero flag not cleared after last coefficient");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !v1 && !v2 && !v3 && !v4 |-> coefs.ready)
    else $error("empty pipeline refuses input");

  a_no_result_from_load: assert property (@(posedge clk) disable iff (rst)
    coefs.valid && coefs.ready && !in_proc |=> !v1)
    else $error("table load entered the pipeline");
`endif

endmodule
